>>> rtl/assert_macros.svh
// Assertion macros shared by the channel effect engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds on a rising edge of clk outside reset.
`define ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> rtl/tcee_pkg.sv
// Types, codes and constants of the channel effect engine.
`default_nettype none

package tcee_pkg;

    localparam int NOTE_COUNT_DEF = 96;
    localparam int VIB_LEN_DEF    = 64;
    localparam int TREM_LEN_DEF   = 64;

    localparam logic [10:0] PERIOD_MAX  = 11'h7FF;
    localparam logic [7:0]  FINE_CENTER = 8'h80;
    localparam logic [4:0]  DEPTH_BIAS  = 5'd2;

    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_CMD     = 3'd1,
        REQ_NOTE    = 3'd2,
        REQ_SILENCE = 3'd3,
        REQ_WRITE   = 3'd4
    } req_e;

    typedef enum logic [2:0] {
        CMD_PORTA = 3'd0,
        CMD_VIB   = 3'd1,
        CMD_TREM  = 3'd2,
        CMD_ARP   = 3'd3,
        CMD_FINE  = 3'd4,
        CMD_DOWN  = 3'd5,
        CMD_UP    = 3'd6
    } cmd_e;

    typedef enum logic [2:0] {
        FX_NONE  = 3'd0,
        FX_PORTA = 3'd1,
        FX_ARP   = 3'd4,
        FX_DOWN  = 3'd6,
        FX_UP    = 3'd7
    } fx_e;

    // Period update carried from the control stage to the period stage.
    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_LOAD       = 3'd1,
        OP_NOTE_PORTA = 3'd2,
        OP_PORTA_TICK = 3'd3,
        OP_DOWN       = 3'd4,
        OP_UP         = 3'd5,
        OP_CLEAR      = 3'd6,
        OP_TGT_CLEAR  = 3'd7
    } op_e;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  eff_cmd;
        logic [7:0]  eff_param;
        logic [6:0]  note;
        logic [10:0] table_value;
    } req_t;

    typedef struct packed {
        logic [10:0] period;
        logic        channel_on;
        logic [5:0]  vib_phase;
        logic [4:0]  vib_depth;
        logic [5:0]  trem_phase;
        logic [4:0]  trem_depth;
        logic [7:0]  fine_tune;
        logic [6:0]  sounding_note;
        logic        cmd_taken;
    } res_t;

    // Result fields settled in the control stage.
    typedef struct packed {
        logic        channel_on;
        logic [5:0]  vib_phase;
        logic [4:0]  vib_depth;
        logic [5:0]  trem_phase;
        logic [4:0]  trem_depth;
        logic [7:0]  fine_tune;
        logic [6:0]  sounding_note;
        logic        cmd_taken;
    } view_t;

    typedef struct packed {
        op_e        op;
        logic [7:0] speed;
        view_t      view;
    } stage_t;

    typedef struct packed {
        logic tick;
        logic set;
        logic clear;
    } lfo_ctl_t;

endpackage

`default_nettype wire

>>> rtl/tcee_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module tcee_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 96
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/tcee_lfo.sv
// Vibrato or tremolo oscillator: speed, depth and wrapping phase.
`default_nettype none

module tcee_lfo
    import tcee_pkg::*;
#(
    parameter int LEN = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire lfo_ctl_t   ctl,
    input  wire logic [7:0] param,
    output logic      [5:0] phase_next,
    output logic      [4:0] depth_next
);

    localparam int PW    = $clog2(LEN);
    localparam int SW    = $clog2(LEN + 15);
    localparam int STEPS = 15 / LEN + 1;

    logic [3:0]    speed_reg, speed_next;
    logic [4:0]    depth_reg, depth_nx;
    logic [PW-1:0] phase_reg, phase_nx;
    logic [SW-1:0] sum;

    always_comb
    begin
        speed_next = speed_reg;
        depth_nx   = depth_reg;
        phase_nx   = phase_reg;
        sum        = SW'(phase_reg) + SW'(speed_reg);
        // wrap the advanced phase back into the table length
        for (int i = 0; i < STEPS; i++)
        begin
            if (sum >= SW'(LEN))
            begin
                sum = sum - SW'(LEN);
            end
        end
        if (ctl.clear)
        begin
            speed_next = '0;
            phase_nx   = '0;
        end
        else if (ctl.set)
        begin
            depth_nx   = 5'(param[3:0]) + DEPTH_BIAS;
            speed_next = param[7:4];
            if (param == 8'h00)
            begin
                phase_nx = '0;
            end
        end
        else if (ctl.tick)
        begin
            phase_nx = PW'(sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= '0;
            depth_reg <= '0;
            phase_reg <= '0;
        end
        else if (en)
        begin
            speed_reg <= speed_next;
            depth_reg <= depth_nx;
            phase_reg <= phase_nx;
        end
    end

    assign phase_next = 6'(phase_nx);
    assign depth_next = depth_nx;

endmodule

`default_nettype wire

>>> rtl/tcee_ctrl.sv
// Control stage: request decode, effect state, table access and stage register.
`default_nettype none

`include "assert_macros.svh"

module tcee_ctrl
    import tcee_pkg::*;
#(
    parameter int NOTE_COUNT = NOTE_COUNT_DEF,
    parameter int VIB_LEN    = VIB_LEN_DEF,
    parameter int TREM_LEN   = TREM_LEN_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire logic                          req_valid,
    input  wire req_t                          req,
    output logic                               ram_we,
    output logic [$clog2(NOTE_COUNT)-1:0]      ram_waddr,
    output logic [10:0]                        ram_wdata,
    output logic [$clog2(NOTE_COUNT)-1:0]      ram_raddr,
    output logic                               s1_valid,
    output stage_t                             s1
);

    localparam int AW = $clog2(NOTE_COUNT);

    function automatic logic [6:0] clamp_note(input logic [7:0] n);
        clamp_note = (n >= 8'(NOTE_COUNT)) ? 7'(NOTE_COUNT - 1) : n[6:0];
    endfunction

    logic       fire;
    logic [6:0] base_note_reg, base_note_next;
    logic [6:0] shown_note_reg, shown_note_next;
    fx_e        effect_reg, effect_next;
    logic [7:0] arp_offsets_reg, arp_offsets_next;
    logic [1:0] arp_step_reg, arp_step_next;
    logic [7:0] speed_reg, speed_next;
    logic [7:0] fine_reg, fine_next;
    logic       playing_reg, playing_next;
    logic       s1_valid_reg;
    stage_t     s1_reg;

    op_e        op;
    logic       taken;
    logic       wr_hit;
    logic [6:0] rd_note;
    logic [6:0] req_note;
    lfo_ctl_t   vib_ctl, trem_ctl;
    logic [5:0] vib_phase, trem_phase;
    logic [4:0] vib_depth, trem_depth;

    assign fire = adv && req_valid;

    always_comb
    begin
        base_note_next   = base_note_reg;
        shown_note_next  = shown_note_reg;
        effect_next      = effect_reg;
        arp_offsets_next = arp_offsets_reg;
        arp_step_next    = arp_step_reg;
        speed_next       = speed_reg;
        fine_next        = fine_reg;
        playing_next     = playing_reg;
        op               = OP_NONE;
        taken            = 1'b0;
        wr_hit           = 1'b0;
        rd_note          = base_note_reg;
        req_note         = clamp_note({1'b0, req.note});
        vib_ctl          = '0;
        trem_ctl         = '0;
        case (req.req_type)
            REQ_TICK:
            begin
                if (playing_reg)
                begin
                    vib_ctl.tick  = 1'b1;
                    trem_ctl.tick = 1'b1;
                    case (effect_reg)
                        FX_ARP:
                        begin
                            if (arp_offsets_reg != 8'h00)
                            begin
                                case (arp_step_reg)
                                    2'd0:
                                    begin
                                        rd_note       = base_note_reg;
                                        op            = OP_LOAD;
                                        arp_step_next = 2'd1;
                                    end
                                    2'd1:
                                    begin
                                        rd_note = clamp_note({1'b0, base_note_reg}
                                                             + 8'(arp_offsets_reg[7:4]));
                                        op      = OP_LOAD;
                                        // skip the third step when its offset is zero
                                        arp_step_next = (arp_offsets_reg[3:0] == 4'h0)
                                                        ? 2'd0 : 2'd2;
                                    end
                                    2'd2:
                                    begin
                                        rd_note = clamp_note({1'b0, base_note_reg}
                                                             + 8'(arp_offsets_reg[3:0]));
                                        op            = OP_LOAD;
                                        arp_step_next = 2'd0;
                                    end
                                    default:
                                    begin
                                        arp_step_next = 2'd0;
                                    end
                                endcase
                                if (op == OP_LOAD)
                                begin
                                    shown_note_next = rd_note;
                                end
                            end
                        end
                        FX_PORTA: op = OP_PORTA_TICK;
                        FX_DOWN:  op = OP_DOWN;
                        FX_UP:    op = OP_UP;
                        default:  op = OP_NONE;
                    endcase
                end
            end
            REQ_CMD:
            begin
                taken = 1'b1;
                case (req.eff_cmd)
                    CMD_PORTA:
                    begin
                        speed_next  = req.eff_param;
                        effect_next = FX_PORTA;
                        if (req.eff_param == 8'h00)
                        begin
                            op = OP_TGT_CLEAR;
                        end
                    end
                    CMD_VIB:  vib_ctl.set  = 1'b1;
                    CMD_TREM: trem_ctl.set = 1'b1;
                    CMD_ARP:
                    begin
                        arp_offsets_next = req.eff_param;
                        effect_next      = FX_ARP;
                    end
                    CMD_FINE: fine_next = req.eff_param;
                    CMD_DOWN:
                    begin
                        speed_next  = req.eff_param;
                        effect_next = FX_DOWN;
                    end
                    CMD_UP:
                    begin
                        speed_next  = req.eff_param;
                        effect_next = FX_UP;
                    end
                    default: taken = 1'b0;
                endcase
            end
            REQ_NOTE:
            begin
                base_note_next  = req_note;
                shown_note_next = req_note;
                rd_note         = req_note;
                arp_step_next   = 2'd0;
                playing_next    = 1'b1;
                op = (effect_reg == FX_PORTA && speed_reg != 8'h00)
                     ? OP_NOTE_PORTA : OP_LOAD;
            end
            REQ_SILENCE:
            begin
                speed_next       = '0;
                arp_offsets_next = '0;
                arp_step_next    = 2'd0;
                vib_ctl.clear    = 1'b1;
                trem_ctl.clear   = 1'b1;
                fine_next        = FINE_CENTER;
                playing_next     = 1'b0;
                op               = OP_CLEAR;
            end
            REQ_WRITE:
            begin
                wr_hit = ({1'b0, req.note} < 8'(NOTE_COUNT));
            end
            default:
            begin
                op = OP_NONE;
            end
        endcase
    end

    tcee_lfo #(
        .LEN(VIB_LEN)
    ) u_vib (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (fire),
        .ctl        (vib_ctl),
        .param      (req.eff_param),
        .phase_next (vib_phase),
        .depth_next (vib_depth)
    );

    tcee_lfo #(
        .LEN(TREM_LEN)
    ) u_trem (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (fire),
        .ctl        (trem_ctl),
        .param      (req.eff_param),
        .phase_next (trem_phase),
        .depth_next (trem_depth)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_note_reg   <= '0;
            shown_note_reg  <= '0;
            effect_reg      <= FX_NONE;
            arp_offsets_reg <= '0;
            arp_step_reg    <= '0;
            speed_reg       <= '0;
            fine_reg        <= FINE_CENTER;
            playing_reg     <= 1'b0;
            s1_valid_reg    <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= req_valid;
            if (req_valid)
            begin
                base_note_reg   <= base_note_next;
                shown_note_reg  <= shown_note_next;
                effect_reg      <= effect_next;
                arp_offsets_reg <= arp_offsets_next;
                arp_step_reg    <= arp_step_next;
                speed_reg       <= speed_next;
                fine_reg        <= fine_next;
                playing_reg     <= playing_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_reg.op                 <= op;
            s1_reg.speed              <= speed_reg;
            s1_reg.view.channel_on    <= playing_next;
            s1_reg.view.vib_phase     <= vib_phase;
            s1_reg.view.vib_depth     <= vib_depth;
            s1_reg.view.trem_phase    <= trem_phase;
            s1_reg.view.trem_depth    <= trem_depth;
            s1_reg.view.fine_tune     <= fine_next;
            s1_reg.view.sounding_note <= shown_note_next;
            s1_reg.view.cmd_taken     <= taken;
        end
    end

    assign ram_we    = fire && wr_hit;
    assign ram_waddr = AW'(req.note);
    assign ram_wdata = req.table_value;
    assign ram_raddr = AW'(rd_note);
    assign s1_valid  = s1_valid_reg;
    assign s1        = s1_reg;

    `ASSERT_NEVER(a_arp_step_legal, arp_step_reg == 2'd3,
                  "arpeggio step left its three-step cycle")
    `ASSERT_ALWAYS(a_hold_on_stall,
                   !adv |=> $stable(base_note_reg) && $stable(arp_step_reg)
                            && $stable(s1_valid_reg),
                   "control state moved while the pipeline was stalled")

endmodule

`default_nettype wire

>>> rtl/tcee_period.sv
// Period stage: applies table data and slides, holds the result register.
`default_nettype none

`include "assert_macros.svh"

module tcee_period
    import tcee_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        adv,
    input  wire logic        s1_valid,
    input  wire stage_t      s1,
    input  wire logic [10:0] rdata,
    output logic             res_valid,
    output res_t             res
);

    logic [10:0] cur_reg, cur_next;
    logic [10:0] tgt_reg, tgt_next;
    logic [11:0] sum;
    logic [10:0] dif;
    logic        res_valid_reg;
    res_t        res_reg;

    always_comb
    begin
        cur_next = cur_reg;
        tgt_next = tgt_reg;
        sum      = {1'b0, cur_reg} + 12'(s1.speed);
        dif      = (cur_reg > 11'(s1.speed)) ? cur_reg - 11'(s1.speed) : '0;
        case (s1.op)
            OP_LOAD: cur_next = rdata;
            OP_NOTE_PORTA:
            begin
                // jump only when no target was set before
                if (tgt_reg == '0)
                begin
                    cur_next = rdata;
                end
                tgt_next = rdata;
            end
            OP_PORTA_TICK:
            begin
                if (s1.speed != 8'h00 && tgt_reg != '0)
                begin
                    if (cur_reg > tgt_reg)
                    begin
                        cur_next = (dif < tgt_reg) ? tgt_reg : dif;
                    end
                    else if (cur_reg < tgt_reg)
                    begin
                        cur_next = (sum > {1'b0, tgt_reg}) ? tgt_reg : sum[10:0];
                    end
                end
            end
            OP_DOWN:
            begin
                cur_next = (sum > {1'b0, PERIOD_MAX}) ? PERIOD_MAX : sum[10:0];
            end
            OP_UP: cur_next = dif;
            OP_CLEAR:
            begin
                cur_next = '0;
                tgt_next = '0;
            end
            OP_TGT_CLEAR: tgt_next = '0;
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            tgt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= s1_valid;
            if (s1_valid)
            begin
                cur_reg <= cur_next;
                tgt_reg <= tgt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid)
        begin
            res_reg.period        <= cur_next;
            res_reg.channel_on    <= s1.view.channel_on;
            res_reg.vib_phase     <= s1.view.vib_phase;
            res_reg.vib_depth     <= s1.view.vib_depth;
            res_reg.trem_phase    <= s1.view.trem_phase;
            res_reg.trem_depth    <= s1.view.trem_depth;
            res_reg.fine_tune     <= s1.view.fine_tune;
            res_reg.sounding_note <= s1.view.sounding_note;
            res_reg.cmd_taken     <= s1.view.cmd_taken;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `ASSERT_ALWAYS(a_period_hold_on_stall,
                   !adv |=> $stable(cur_reg) && $stable(tgt_reg),
                   "period state moved while the result was stalled")

endmodule

`default_nettype wire

>>> rtl/tracker_channel_effect_engine_unit.sv
// Top level of the per-channel tracker effect engine.
//
// Usage:
//   Requests enter on req (valid/ready): frame tick, effect command, note on,
//   silence or period table write. Every accepted request yields exactly one
//   item on res (valid/ready) with the channel period after effects, the
//   vibrato and tremolo phase and depth, fine pitch, sounding note and a flag
//   for a recognised effect command.
//   A result passes the control stage with the table read, then the period
//   stage, and is registered at the end of each.
//   Throughput: one request per cycle while res is not stalled; the table
//   memory has one write and one read port, a write is seen by the very next request.
//   Reset: all channel state clears, fine pitch returns to center, the channel
//   is silent. The period table holds nothing useful until it is written.
//   Stall: while res is valid and not taken the whole pipeline holds and
//   req_ready drops; it stays high whenever the result register is empty.
`default_nettype none

`include "assert_macros.svh"

module tracker_channel_effect_engine_unit
    import tcee_pkg::*;
#(
    parameter int NOTE_COUNT = NOTE_COUNT_DEF,
    parameter int VIB_LEN    = VIB_LEN_DEF,
    parameter int TREM_LEN   = TREM_LEN_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      res_valid,
    input  wire logic res_ready,
    output res_t      res
);

    localparam int AW = $clog2(NOTE_COUNT);

    logic          adv;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [10:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [10:0]   ram_rdata;
    logic          s1_valid;
    stage_t        s1;

    // advance the pipeline whenever the result register can take a new item
    assign adv       = !res_valid || res_ready;
    assign req_ready = adv;

    tcee_ctrl #(
        .NOTE_COUNT (NOTE_COUNT),
        .VIB_LEN    (VIB_LEN),
        .TREM_LEN   (TREM_LEN)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .req_valid (req_valid),
        .req       (req),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .s1_valid  (s1_valid),
        .s1        (s1)
    );

    tcee_ram #(
        .WIDTH (11),
        .DEPTH (NOTE_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (adv),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tcee_period u_period (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .s1_valid  (s1_valid),
        .s1        (s1),
        .rdata     (ram_rdata),
        .res_valid (res_valid),
        .res       (res)
    );

    `ASSERT_ALWAYS(a_ready_when_empty, !res_valid |-> req_ready,
                   "request side blocked with an empty result register")

endmodule

`default_nettype wire

>>> tb/tcee_channel_checker.sv
// Scoreboard for the channel effect engine: predicts every result and compares it.
module tcee_channel_checker
    import tcee_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic res_valid,
    input  logic res_ready,
    input  res_t res,
    output int   mismatches,
    output int   checked,
    output int   backlog
);

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the channel state.
    logic [11:0] cur_period;
    logic [6:0]  base_note;
    logic [6:0]  shown_note;
    fx_e         active_fx;
    logic [7:0]  arp_offsets;
    logic [1:0]  arp_step;
    logic [7:0]  slide_speed;
    logic [11:0] slide_target;
    logic [3:0]  vib_speed;
    logic [4:0]  vib_depth;
    logic [5:0]  vib_phase;
    logic [3:0]  trem_speed;
    logic [4:0]  trem_depth;
    logic [5:0]  trem_phase;
    logic [7:0]  fine;
    logic        playing;
    logic [10:0] periods [NOTE_COUNT_DEF];

    res_t        channel_snapshots [$];

    // Read the table with the note saturated to the top entry; track the shown note.
    function automatic logic [11:0] fetch_period(input int unsigned n);
        int unsigned idx;
        idx = (n >= NOTE_COUNT_DEF) ? NOTE_COUNT_DEF - 1 : n;
        shown_note = 7'(idx);
        return {1'b0, periods[idx]};
    endfunction

    task automatic apply_request(input req_t r, output res_t o);
        int unsigned cp;
        int unsigned sp;
        int unsigned tg;
        int unsigned step;
        int unsigned n;
        logic [11:0] per;
        logic        taken;
        taken = 1'b0;
        case (r.req_type)
            REQ_TICK:
            begin
                if (playing)
                begin
                    vib_phase  = 6'((vib_phase + vib_speed) % VIB_LEN_DEF);
                    trem_phase = 6'((trem_phase + trem_speed) % TREM_LEN_DEF);
                    cp = 32'(cur_period);
                    sp = 32'(slide_speed);
                    tg = 32'(slide_target);
                    case (active_fx)
                        FX_ARP:
                        begin
                            if (arp_offsets != 8'd0)
                            begin
                                step = 32'(arp_step);
                                case (step)
                                    0: cp = 32'(fetch_period(32'(base_note)));
                                    1:
                                    begin
                                        cp = 32'(fetch_period(32'(base_note)
                                                              + 32'(arp_offsets[7:4])));
                                        // skip the third step when its offset is zero
                                        if (arp_offsets[3:0] == 4'd0)
                                            step = 2;
                                    end
                                    2:
                                        cp = 32'(fetch_period(32'(base_note)
                                                              + 32'(arp_offsets[3:0])));
                                    default: ;
                                endcase
                                step = step + 1;
                                if (step > 2)
                                    step = 0;
                                arp_step = 2'(step);
                            end
                        end
                        FX_PORTA:
                        begin
                            if (sp > 0 && tg > 0)
                            begin
                                if (cp > tg)
                                begin
                                    cp = (cp > sp) ? cp - sp : 0;
                                    if (cp < tg)
                                        cp = tg;
                                end
                                else if (cp < tg)
                                begin
                                    cp = cp + sp;
                                    if (cp > tg)
                                        cp = tg;
                                end
                            end
                        end
                        FX_DOWN:
                        begin
                            cp = cp + sp;
                            if (cp > PERIOD_MAX)
                                cp = 32'(PERIOD_MAX);
                        end
                        FX_UP:
                            cp = (cp > sp) ? cp - sp : 0;
                        default: ;
                    endcase
                    cur_period = 12'(cp);
                end
            end
            REQ_CMD:
            begin
                taken = 1'b1;
                case (r.eff_cmd)
                    CMD_PORTA:
                    begin
                        slide_speed = r.eff_param;
                        active_fx   = FX_PORTA;
                        if (r.eff_param == 8'd0)
                            slide_target = 12'd0;
                    end
                    CMD_VIB:
                    begin
                        vib_depth = {1'b0, r.eff_param[3:0]} + DEPTH_BIAS;
                        vib_speed = r.eff_param[7:4];
                        if (r.eff_param == 8'd0)
                            vib_phase = 6'd0;
                    end
                    CMD_TREM:
                    begin
                        trem_depth = {1'b0, r.eff_param[3:0]} + DEPTH_BIAS;
                        trem_speed = r.eff_param[7:4];
                        if (r.eff_param == 8'd0)
                            trem_phase = 6'd0;
                    end
                    CMD_ARP:
                    begin
                        arp_offsets = r.eff_param;
                        active_fx   = FX_ARP;
                    end
                    CMD_FINE:
                        fine = r.eff_param;
                    CMD_DOWN:
                    begin
                        slide_speed = r.eff_param;
                        active_fx   = FX_DOWN;
                    end
                    CMD_UP:
                    begin
                        slide_speed = r.eff_param;
                        active_fx   = FX_UP;
                    end
                    default: taken = 1'b0;
                endcase
            end
            REQ_NOTE:
            begin
                n = 32'(r.note);
                if (n >= NOTE_COUNT_DEF)
                    n = NOTE_COUNT_DEF - 1;
                base_note = 7'(n);
                per       = fetch_period(n);
                arp_step  = 2'd0;
                playing   = 1'b1;
                // under portamento the new note becomes the target; jump only from no target
                if (active_fx == FX_PORTA && slide_speed != 8'd0)
                begin
                    if (slide_target == 12'd0)
                        cur_period = per;
                    slide_target = per;
                end
                else
                    cur_period = per;
            end
            REQ_SILENCE:
            begin
                slide_speed  = 8'd0;
                arp_offsets  = 8'd0;
                arp_step     = 2'd0;
                vib_speed    = 4'd0;
                vib_phase    = 6'd0;
                trem_speed   = 4'd0;
                trem_phase   = 6'd0;
                fine         = FINE_CENTER;
                cur_period   = 12'd0;
                playing      = 1'b0;
                slide_target = 12'd0;
            end
            REQ_WRITE:
            begin
                if (r.note < NOTE_COUNT_DEF)
                    periods[r.note] = r.table_value;
            end
            default: ;
        endcase
        o.period        = cur_period[10:0];
        o.channel_on    = playing;
        o.vib_phase     = vib_phase;
        o.vib_depth     = vib_depth;
        o.trem_phase    = trem_phase;
        o.trem_depth    = trem_depth;
        o.fine_tune     = fine;
        o.sounding_note = shown_note;
        o.cmd_taken     = taken;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        if (!rst_n)
        begin
            cur_period   = 12'd0;
            base_note    = 7'd0;
            shown_note   = 7'd0;
            active_fx    = FX_NONE;
            arp_offsets  = 8'd0;
            arp_step     = 2'd0;
            slide_speed  = 8'd0;
            slide_target = 12'd0;
            vib_speed    = 4'd0;
            vib_depth    = 5'd0;
            vib_phase    = 6'd0;
            trem_speed   = 4'd0;
            trem_depth   = 5'd0;
            trem_phase   = 6'd0;
            fine         = FINE_CENTER;
            playing      = 1'b0;
            for (int i = 0; i < NOTE_COUNT_DEF; i++)
                periods[i] = 11'd0;
            channel_snapshots.delete();
            mismatches = 0;
            checked    = 0;
            backlog    = 0;
        end
        else
        begin
            // push before pop so that ordering holds even for a same-edge result
            if (req_valid && req_ready)
            begin
                apply_request(req, want);
                channel_snapshots.push_back(want);
            end
            if (res_valid && res_ready)
            begin
                if (channel_snapshots.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result with nothing pending: %p", res);
                end
                else
                begin
                    want = channel_snapshots.pop_front();
                    if (res !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display({"result %0d mismatch, expected: period=%0d on=%0b",
                                      " vib=%0d/%0d trem=%0d/%0d fine=%0d note=%0d taken=%0b"},
                                     checked, want.period, want.channel_on, want.vib_phase,
                                     want.vib_depth, want.trem_phase, want.trem_depth,
                                     want.fine_tune, want.sounding_note, want.cmd_taken);
                            $display({"result %0d mismatch, actual:   period=%0d on=%0b",
                                      " vib=%0d/%0d trem=%0d/%0d fine=%0d note=%0d taken=%0b"},
                                     checked, res.period, res.channel_on, res.vib_phase,
                                     res.vib_depth, res.trem_phase, res.trem_depth,
                                     res.fine_tune, res.sounding_note, res.cmd_taken);
                        end
                    end
                    checked++;
                end
            end
            backlog = channel_snapshots.size();
        end
    end

endmodule

>>> tb/tb_tracker_channel_effect_engine_unit.sv
// Testbench top: drives requests and result stalls into the effect engine and gives the verdict.
module tb_tracker_channel_effect_engine_unit;
    import tcee_pkg::*;

    localparam logic [2:0] CODE_TOP     = 3'd7;     // highest value a 3-bit code can take
    localparam logic [2:0] CMD_BAD      = CODE_TOP;
    localparam int         IDLE_PCT     = 22;
    localparam int         RANDOM_ITEMS = 1000;
    localparam int         STEADY_FROM  = 300;
    localparam int         STEADY_TO    = 500;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic res_valid;
    logic res_ready;
    res_t res;
    logic steady;

    int mismatches;
    int checked;
    int backlog;
    int n_ticks = 0;
    int n_cmds = 0;
    int n_notes = 0;
    int n_other = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    tracker_channel_effect_engine_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    tcee_channel_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mismatches (mismatches),
        .checked    (checked),
        .backlog    (backlog)
    );

    // Stall the result side at random, except inside the steady window.
    always @(negedge clk)
        res_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);

    function automatic req_t make_req(input logic [2:0] kind, input logic [2:0] cmd,
                                      input logic [7:0] param, input logic [6:0] note,
                                      input logic [10:0] value);
        req_t r;
        r.req_type    = kind;
        r.eff_cmd     = cmd;
        r.eff_param   = param;
        r.note        = note;
        r.table_value = value;
        return r;
    endfunction

    function automatic req_t random_request();
        req_t        r;
        int unsigned roll;
        // start from noise so that fields the request does not use still toggle
        r    = req_t'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 42)
            r.req_type = REQ_TICK;
        else if (roll < 67)
        begin
            r.req_type = REQ_CMD;
            r.eff_cmd  = 3'($urandom_range(0, CODE_TOP));
            case ($urandom_range(0, 7))
                0: r.eff_param = 8'h00;
                1: r.eff_param = 8'hFF;
                2: r.eff_param = 8'($urandom_range(0, 15));
                default: r.eff_param = 8'($urandom);
            endcase
        end
        else if (roll < 82)
        begin
            r.req_type = REQ_NOTE;
            r.note     = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(NOTE_COUNT_DEF, 127))
                                                     : 7'($urandom_range(0, NOTE_COUNT_DEF - 1));
        end
        else if (roll < 88)
            r.req_type = REQ_SILENCE;
        else if (roll < 96)
        begin
            r.req_type = REQ_WRITE;
            r.note     = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(NOTE_COUNT_DEF, 127))
                                                     : 7'($urandom_range(0, NOTE_COUNT_DEF - 1));
            case ($urandom_range(0, 7))
                0: r.table_value = 11'd0;
                1: r.table_value = PERIOD_MAX;
                default: r.table_value = 11'($urandom_range(1, PERIOD_MAX));
            endcase
        end
        else
            r.req_type = 3'($urandom_range(REQ_WRITE + 1, CODE_TOP));
        return r;
    endfunction

    // Offer one item, idling first at random; return at the falling edge after acceptance.
    task automatic post(input req_t item);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            req       <= req_t'($urandom);
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        case (item.req_type)
            REQ_TICK: n_ticks++;
            REQ_CMD:  n_cmds++;
            REQ_NOTE: n_notes++;
            default:  n_other++;
        endcase
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    initial
    begin
        logic [10:0] value;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        steady    = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Requests that never read the table.
        post(make_req(REQ_TICK, CMD_PORTA, 8'h00, 7'd0, 11'd0));
        post(make_req(3'(REQ_WRITE + 1), CMD_BAD, 8'hFF, 7'h7F, PERIOD_MAX));
        post(make_req(CODE_TOP, CMD_BAD, 8'hFF, 7'h7F, PERIOD_MAX));
        post(make_req(REQ_WRITE, CMD_PORTA, 8'h00, 7'h7F, PERIOD_MAX));
        post(make_req(REQ_CMD, CMD_VIB, 8'hFF, 7'd0, 11'd0));
        post(make_req(REQ_CMD, CMD_TREM, 8'hFF, 7'd0, 11'd0));
        post(make_req(REQ_CMD, CMD_FINE, 8'hFF, 7'd0, 11'd0));
        post(make_req(REQ_CMD, CMD_BAD, 8'h5A, 7'd0, 11'd0));
        post(make_req(REQ_SILENCE, CMD_PORTA, 8'h00, 7'd0, 11'd0));

        // Load every table entry so that no later lookup hits an unwritten one.
        for (int i = 0; i < NOTE_COUNT_DEF; i++)
        begin
            if (i == 0)
                value = 11'd0;
            else if (i == 1)
                value = 11'd3;
            else if (i == NOTE_COUNT_DEF - 1)
                value = PERIOD_MAX;
            else
                value = 11'($urandom_range(1, PERIOD_MAX));
            post(make_req(REQ_WRITE, CMD_PORTA, 8'h00, 7'(i), value));
        end

        // Saturation at the top note, slide clamps, arpeggio skip and overflow, portamento.
        post(make_req(REQ_NOTE, CMD_PORTA, 8'h00, 7'h7F, 11'd0));
        post(make_req(REQ_CMD, CMD_DOWN, 8'hFF, 7'd0, 11'd0));
        post(make_req(REQ_TICK, CMD_PORTA, 8'h00, 7'd0, 11'd0));
        post(make_req(REQ_CMD, CMD_UP, 8'hFF, 7'd0, 11'd0));
        post(make_req(REQ_NOTE, CMD_PORTA, 8'h00, 7'd1, 11'd0));
        post(make_req(REQ_TICK, CMD_PORTA, 8'h00, 7'd0, 11'd0));
        post(make_req(REQ_CMD, CMD_ARP, 8'hF0, 7'd0, 11'd0));
        post(make_req(REQ_NOTE, CMD_PORTA, 8'h00, 7'd90, 11'd0));
        repeat (3) post(make_req(REQ_TICK, CMD_PORTA, 8'h00, 7'd0, 11'd0));
        post(make_req(REQ_CMD, CMD_ARP, 8'h37, 7'd0, 11'd0));
        repeat (3) post(make_req(REQ_TICK, CMD_PORTA, 8'h00, 7'd0, 11'd0));
        post(make_req(REQ_CMD, CMD_PORTA, 8'h10, 7'd0, 11'd0));
        post(make_req(REQ_NOTE, CMD_PORTA, 8'h00, 7'd40, 11'd0));
        post(make_req(REQ_NOTE, CMD_PORTA, 8'h00, 7'd60, 11'd0));
        repeat (2) post(make_req(REQ_TICK, CMD_PORTA, 8'h00, 7'd0, 11'd0));
        post(make_req(REQ_CMD, CMD_PORTA, 8'h00, 7'd0, 11'd0));
        post(make_req(REQ_SILENCE, CMD_PORTA, 8'h00, 7'd0, 11'd0));

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady = (i >= STEADY_FROM && i < STEADY_TO);
            post(random_request());
        end
        steady    = 1'b0;
        req_valid <= 1'b0;

        wait (backlog == 0);
        repeat (8) @(posedge clk);
        $display("drove %0d requests: %0d frame ticks, %0d effect commands, %0d note ons, %0d other",
                 n_ticks + n_cmds + n_notes + n_other, n_ticks, n_cmds, n_notes, n_other);
        $display("compared %0d results field by field, %0d mismatches", checked, mismatches);
        if (mismatches == 0 && backlog == 0)
            $display("tb_tracker_channel_effect_engine_unit OK");
        else
            $display("tb_tracker_channel_effect_engine_unit NOT OK");
        $finish;
    end

    initial
    begin
        #400000;
        $display("run timed out");
        $display("tb_tracker_channel_effect_engine_unit NOT OK");
        $finish;
    end

endmodule
